// ===== sv/masked_signature_scanner_defines.svh =====
// Assertion macros for the checker file of the masked signature scanner.
`ifndef MASKED_SIGNATURE_SCANNER_DEFINES_SVH
`define MASKED_SIGNATURE_SCANNER_DEFINES_SVH

// Clocked assertion that is held off while reset is asserted.
`define MSIG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define MSIG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

// ===== sv/msig_pkg.sv =====
// Package with the shared constants and types of the masked signature scanner.
`default_nettype none

package msig_pkg;

    localparam int MAX_PATTERN_LEN = 8;
    localparam int NUM_SIGNATURES  = 3;

    localparam int WIN_DEPTH  = MAX_PATTERN_LEN - 1;
    localparam int SEQ_W      = 8 * MAX_PATTERN_LEN;
    localparam int POS_W      = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LEN_W      = 4;
    localparam int SEEN_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MASK_W     = 8 * NUM_SIGNATURES;
    localparam int LENS_W     = LEN_W * NUM_SIGNATURES;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASKS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTHS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_LIMIT  = 3'd5;

    typedef logic [1:0] verdict_t;
    localparam verdict_t VERDICT_NONE    = 2'd0;
    localparam verdict_t VERDICT_PARTIAL = 2'd1;
    localparam verdict_t VERDICT_FULL    = 2'd2;

    typedef logic [1:0] sig_idx_t;

    typedef struct packed {
        verdict_t verdict;
        sig_idx_t matched_signature;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/msig_match.sv =====
// Masked compare of one signature against the current byte and the byte window.
`default_nettype none

module msig_match
    import msig_pkg::*;
(
    input  logic [SEQ_W-1:0]           seq,      // byte 0 is the newest byte
    input  logic [SEQ_W-1:0]           pattern,
    input  logic [MAX_PATTERN_LEN-1:0] mask,
    input  logic [LEN_W-1:0]           len,
    input  logic [SEEN_W-1:0]          seen,
    output logic                       hit
);

    logic             len_ok;
    logic             enough;
    logic             miss;
    logic [POS_W-1:0] pos;
    logic [7:0]       got;
    logic [7:0]       want;

    assign len_ok = (len != '0) && (len <= LEN_W'(MAX_PATTERN_LEN));
    // Enough scanned bytes, counting the current one, to cover the signature.
    assign enough = ({1'b0, seen} + 33'd1) >= 33'(len);

    // Signature byte i lines up with the byte that arrived len-1-i items ago.
    always_comb
    begin
        miss = 1'b0;
        pos  = '0;
        got  = '0;
        want = '0;
        for (int i = 0; i < MAX_PATTERN_LEN; i++)
        begin
            pos  = POS_W'(int'(len) - 1 - i);
            got  = seq[8*pos +: 8];
            want = pattern[8*i +: 8];
            if ((i < int'(len)) && mask[i] && (got != want))
            begin
                miss = 1'b1;
            end
        end
    end

    assign hit = len_ok && enough && !miss;

endmodule

`default_nettype wire

// ===== sv/masked_signature_scanner.sv =====
// Top level of the masked signature scanner: registers, window, flags and verdict.
//
//   Channel   Direction  Payload                                  Handshake
//   s_*       in         tdata[7:0] image_byte, tlast final_byte  tvalid/tready
//   m_*       out        tdata[1:0] verdict, [3:2] matched_sig    tvalid/tready
//   cfg_*     in         cfg_index selects, cfg_data holds value  cfg_we
//
// A byte is taken into the input register and scanned in the following cycle,
// unless it is a final byte that must wait; the verdict of a final byte is
// loaded into the output register when it advances, and drives m_tvalid from there.
// The block sustains one byte per cycle; only a final byte can wait, and only
// while an earlier verdict still stands unaccepted in the output register.
// Reset clears the window, byte count, hit flags and all configuration
// registers (scan_limit to all ones); no clearing pass is needed.
`default_nettype none

module masked_signature_scanner
    import msig_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] image_byte
    input  logic                  s_tlast,   // final_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // [1:0] verdict, [3:2] matched_signature
);

    // Configuration registers.
    logic [SEQ_W-1:0]  pattern_reg [NUM_SIGNATURES];
    logic [MASK_W-1:0] masks_reg;
    logic [LENS_W-1:0] lengths_reg;
    logic [SEEN_W-1:0] limit_reg;

    // Input register.
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;

    // Scan state.
    logic [7:0]        win_reg [WIN_DEPTH];
    logic [SEEN_W-1:0] seen_reg;
    logic [NUM_SIGNATURES-1:0] hit_reg;
    logic [NUM_SIGNATURES-1:0] hit_next;
    logic [NUM_SIGNATURES-1:0] sig_hit;

    // Output register.
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_next;

    logic              advance;
    logic              scanning;
    logic [SEQ_W-1:0]  seq;

    // A non-final byte always moves on; a final byte needs room for its verdict.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign scanning = advance && (seen_reg < limit_reg);

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SIGNATURES; s++)
            begin
                pattern_reg[s] <= '0;
            end
            masks_reg   <= '0;
            lengths_reg <= '0;
            limit_reg   <= '1;
        end
        else if (cfg_we)
        begin
            priority if (cfg_index == REG_MASKS)
            begin
                masks_reg <= MASK_W'(cfg_data);
            end
            else if (cfg_index == REG_LENGTHS)
            begin
                lengths_reg <= LENS_W'(cfg_data);
            end
            else if (cfg_index == REG_SCAN_LIMIT)
            begin
                limit_reg <= cfg_data[SEEN_W-1:0];
            end
            else
            begin
                for (int s = 0; s < NUM_SIGNATURES; s++)
                begin
                    if (cfg_index == CFG_IDX_W'(s))
                    begin
                        pattern_reg[s] <= cfg_data;
                    end
                end
            end
        end
    end

    // Input register, loaded whenever the slave side completes a transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Newest byte first, then the window from most to least recent.
    always_comb
    begin
        seq[7:0] = in_byte_reg;
        for (int j = 1; j < MAX_PATTERN_LEN; j++)
        begin
            seq[8*j +: 8] = win_reg[j-1];
        end
    end

    // One compare unit per signature, all working on the same byte.
    for (genvar s = 0; s < NUM_SIGNATURES; s++)
    begin : g_sig
        msig_match u_match (
            .seq     (seq),
            .pattern (pattern_reg[s]),
            .mask    (masks_reg[8*s +: MAX_PATTERN_LEN]),
            .len     (lengths_reg[LEN_W*s +: LEN_W]),
            .seen    (seen_reg),
            .hit     (sig_hit[s])
        );
    end

    assign hit_next = scanning ? (hit_reg | sig_hit) : hit_reg;

    // The lowest index above signature 0 wins; signature 0 alone is partial.
    always_comb
    begin
        out_next.verdict           = VERDICT_NONE;
        out_next.matched_signature = '0;
        for (int s = NUM_SIGNATURES - 1; s > 0; s--)
        begin
            if (hit_next[s])
            begin
                out_next.verdict           = VERDICT_FULL;
                out_next.matched_signature = sig_idx_t'(s);
            end
        end
        if ((out_next.verdict == VERDICT_NONE) && hit_next[0])
        begin
            out_next.verdict = VERDICT_PARTIAL;
        end
    end

    // Scan state: bytes past the limit are neither compared nor windowed, and
    // the final byte returns everything to its start state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_DEPTH; k++)
            begin
                win_reg[k] <= '0;
            end
            seen_reg <= '0;
            hit_reg  <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                for (int k = 0; k < WIN_DEPTH; k++)
                begin
                    win_reg[k] <= '0;
                end
                seen_reg <= '0;
                hit_reg  <= '0;
            end
            else if (scanning)
            begin
                win_reg[0] <= in_byte_reg;
                for (int k = 1; k < WIN_DEPTH; k++)
                begin
                    win_reg[k] <= win_reg[k-1];
                end
                seen_reg <= seen_reg + 1'b1;
                hit_reg  <= hit_next;
            end
        end
    end

    // Output register holding one verdict until the master side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.matched_signature, out_reg.verdict};

endmodule

`default_nettype wire

// ===== sv/msig_checker.sv =====
// Port-level assertion checker for the masked signature scanner, with its bind.
`default_nettype none

`include "masked_signature_scanner_defines.svh"

module msig_checker
    import msig_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata
);

    logic stalled;
    logic code_ok;
    logic pad_ok;
    logic index_ok;

    assign stalled  = m_tvalid && !m_tready;
    assign code_ok  = (m_tdata[1:0] == VERDICT_NONE) ||
                      (m_tdata[1:0] == VERDICT_PARTIAL) ||
                      (m_tdata[1:0] == VERDICT_FULL);
    assign pad_ok   = (m_tdata[7:4] == 4'd0);
    assign index_ok = ((m_tdata[1:0] == VERDICT_FULL) == (m_tdata[3:2] != 2'd0));

    // A verdict that waits on the master side must not change.
    `MSIG_ASSERT(a_out_hold, stalled |=> (m_tvalid && $stable(m_tdata)), "held verdict changed")

    // Only the three defined verdict codes appear, with zero padding above.
    `MSIG_ASSERT(a_verdict_code, m_tvalid |-> (code_ok && pad_ok), "bad verdict code")

    // A full verdict names a signature above 0; otherwise the index is 0.
    `MSIG_ASSERT(a_index_match, m_tvalid |-> index_ok, "signature index disagrees with verdict")

    // Nothing is presented on the master side in the cycle after a reset cycle.
    `MSIG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid, "verdict valid out of reset")

endmodule

bind masked_signature_scanner msig_checker u_msig_checker (.*);

`default_nettype wire

// ===== verif/masked_signature_scanner_tb.sv =====
// Self-checking testbench for the masked signature scanner: stream stimulus and verdict scoreboard.
`timescale 1ns / 1ps

module masked_signature_scanner_tb;
    import msig_pkg::*;

    // Register indexes past the last real register. Writes to them must not
    // disturb any setting.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    // Number of image bytes that one random phase sends, rounded up to whole images.
    localparam int PHASE_BYTES = 58;
    localparam int RANDOM_PHASES = 8;

    // Back-pressure profiles that the phases cycle through.
    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    // Tracks the scanner's configuration and image state, works out the
    // verdict that each final byte must produce, and checks the verdicts
    // that come out of the block in order.
    class verdict_scoreboard;
        logic [CFG_DATA_W-1:0]     sig_bytes [NUM_SIGNATURES];
        logic [MASK_W-1:0]         sig_masks;
        logic [LENS_W-1:0]         sig_lens;
        logic [SEEN_W-1:0]         limit;
        logic [7:0]                window [WIN_DEPTH];
        logic [SEEN_W-1:0]         seen;
        logic [NUM_SIGNATURES-1:0] hits;
        result_t                   verdicts_due [$];
        int                        errors;

        function new();
            for (int s = 0; s < NUM_SIGNATURES; s++)
                sig_bytes[s] = '0;
            sig_masks = '0;
            sig_lens  = '0;
            limit     = '1;
            errors    = 0;
            clear_image();
        endfunction

        function void clear_image();
            for (int k = 0; k < WIN_DEPTH; k++)
                window[k] = 8'h00;
            seen = '0;
            hits = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PATTERN_0:  sig_bytes[0] = data;
                REG_PATTERN_1:  sig_bytes[1] = data;
                REG_PATTERN_2:  sig_bytes[2] = data;
                REG_MASKS:      sig_masks = data[MASK_W-1:0];
                REG_LENGTHS:    sig_lens = data[LENS_W-1:0];
                REG_SCAN_LIMIT: limit = data[SEEN_W-1:0];
                default: ;
            endcase
        endfunction

        // True when signature s ends at the byte cur, given the bytes before it.
        function bit signature_hits(int s, logic [7:0] cur);
            int         len;
            logic [7:0] want;
            logic [7:0] got;
            len = sig_lens[LEN_W*s +: LEN_W];
            if (len == 0 || len > MAX_PATTERN_LEN)
                return 1'b0;
            // Not enough scanned bytes yet to hold the whole signature.
            if (seen < SEEN_W'(len - 1))
                return 1'b0;
            for (int i = 0; i < len; i++)
            begin
                want = sig_bytes[s][8*i +: 8];
                got  = (i == len - 1) ? cur : window[len - 2 - i];
                if (sig_masks[8*s + i] && got != want)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // Called for every accepted input transaction.
        function void note_byte(logic [7:0] b, logic is_final);
            result_t r;
            if (seen < limit)
            begin
                for (int s = 0; s < NUM_SIGNATURES; s++)
                    if (signature_hits(s, b))
                        hits[s] = 1'b1;
                for (int k = WIN_DEPTH - 1; k > 0; k--)
                    window[k] = window[k - 1];
                window[0] = b;
                seen = seen + 1'b1;
            end
            if (is_final)
            begin
                r.verdict = VERDICT_NONE;
                r.matched_signature = '0;
                // Walk downward so that the lowest hitting index is kept.
                for (int s = NUM_SIGNATURES - 1; s >= 1; s--)
                    if (hits[s])
                    begin
                        r.verdict = VERDICT_FULL;
                        r.matched_signature = sig_idx_t'(s);
                    end
                if (r.verdict == VERDICT_NONE && hits[0])
                    r.verdict = VERDICT_PARTIAL;
                verdicts_due.push_back(r);
                clear_image();
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        // Called for every accepted output transaction.
        task check_result(logic [7:0] tdata);
            result_t want;
            if (verdicts_due.size() == 0)
            begin
                report("verdict with none pending", tdata, 8'h00);
                return;
            end
            want = verdicts_due.pop_front();
            if (tdata[1:0] !== want.verdict)
                report("verdict", {6'b0, tdata[1:0]}, {6'b0, want.verdict});
            if (tdata[3:2] !== want.matched_signature)
                report("matched_signature", {6'b0, tdata[3:2]}, {6'b0, want.matched_signature});
            if (tdata[7:4] !== 4'h0)
                report("tdata padding", {4'h0, tdata[7:4]}, 8'h00);
        endtask

        task leftover_check();
            if (verdicts_due.size() != 0)
                report("verdicts never delivered", 8'(verdicts_due.size()), 8'h00);
        endtask
    endclass

    // Clock, reset and every block input start at known values.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;   // [7:0] image_byte
    logic                  s_tlast = 1'b0;    // final_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;           // [1:0] verdict, [3:2] matched_signature

    verdict_scoreboard sb;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    logic [7:0]        image_buf [64];

    masked_signature_scanner u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Receiving side. The handshake is judged on the values that held just
    // before the edge; the ready for the next cycle is then drawn at random
    // according to the current stall profile.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct <= 0;  end
            IDLE_SENDER:   begin send_idle_pct = 76; stall_pct <= 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct <= 76; end
            default:       begin send_idle_pct = 14; stall_pct <= 14; end
        endcase
    endtask

    // One register write per clock edge; the scoreboard takes the same value.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one image byte and waits until the transaction is accepted. The
    // valid is only lowered when an idle gap is actually taken, so back-to-back
    // transactions keep it high without a second assignment in the same step.
    task automatic send_byte(input logic [7:0] b, input logic is_final);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_final;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b, is_final);
    endtask

    // Sends a whole image of n bytes, first byte in the lowest bits.
    task automatic send_packed(input logic [63:0] bytes, input int n);
        for (int i = 0; i < n; i++)
            send_byte(bytes[8*i +: 8], i == n - 1);
    endtask

    // Waits until every verdict has come out and the pipeline has emptied,
    // so that the configuration may be changed safely.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Copies signature s into the image buffer at a random spot. Wildcard
    // bytes keep their random content. With corrupt set, one byte of the
    // copy gets a flipped bit, which usually spoils the match.
    task automatic plant_signature(input int s, input int img_len, input bit corrupt);
        int len;
        int pos;
        int k;
        len = sb.sig_lens[LEN_W*s +: LEN_W];
        if (len == 0 || len > MAX_PATTERN_LEN || len > img_len)
            return;
        pos = $urandom_range(0, img_len - len);
        for (int i = 0; i < len; i++)
            if (sb.sig_masks[8*s + i])
                image_buf[pos + i] = sb.sig_bytes[s][8*i +: 8];
        if (corrupt)
        begin
            k = $urandom_range(0, len - 1);
            image_buf[pos + k] ^= 8'(1 << $urandom_range(0, 7));
        end
    endtask

    // Draws a fresh setting for every register. Lengths lean toward usable
    // values, with some disabled and some oversized; limits are often short
    // so that bytes past the limit show up often.
    task automatic random_config();
        logic [63:0] noise;
        logic [23:0] masks;
        logic [11:0] lens;
        logic [31:0] lim;
        logic [3:0]  nib;
        noise = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       masks = '0;
            1:       masks = '1;
            default: masks = 24'($urandom);
        endcase
        lens = '0;
        for (int s = 0; s < NUM_SIGNATURES; s++)
        begin
            case ($urandom_range(0, 9))
                0:       nib = 4'd0;
                1:       nib = 4'($urandom_range(9, 15));
                default: nib = 4'($urandom_range(1, 8));
            endcase
            lens[LEN_W*s +: LEN_W] = nib;
        end
        case ($urandom_range(0, 3))
            0:       lim = 32'hFFFF_FFFF;
            1:       lim = $urandom;
            default: lim = 32'($urandom_range(1, 24));
        endcase
        write_reg(REG_PATTERN_0, {$urandom, $urandom});
        write_reg(REG_PATTERN_1, {$urandom, $urandom});
        write_reg(REG_PATTERN_2, {$urandom, $urandom});
        // Upper bits of the narrow registers carry noise that must be dropped.
        write_reg(REG_MASKS, {noise[63:24], masks});
        write_reg(REG_LENGTHS, {noise[63:12], lens});
        write_reg(REG_SCAN_LIMIT, {noise[63:32], lim});
        if ($urandom_range(0, 1) != 0)
            write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_6 : REG_UNUSED_7,
                      {$urandom, $urandom});
        end_writes();
    endtask

    // Main stimulus.
    initial
    begin
        int sent;
        int img_len;
        int kind;
        sb = new();
        set_idling(IDLE_NONE);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset every length is zero, so nothing may match.
        send_packed(64'hFF00, 2);
        drain_block();

        // Signature 0 is the pair AB CD, signature 1 is eight FF bytes with
        // byte 6 as a wildcard, signature 2 has an oversized length.
        write_reg(REG_PATTERN_0, 64'h0000_0000_0000_CDAB);
        write_reg(REG_PATTERN_1, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PATTERN_2, 64'h0000_0000_0000_0000);
        write_reg(REG_MASKS, 64'h00_BF_FF);
        write_reg(REG_LENGTHS, 64'hF82);
        end_writes();
        send_packed(64'hCDAB, 2);                    // partial: signature 0 alone
        send_packed(64'hAB, 1);                      // the window is cleared by the
        send_packed(64'hCD, 1);                      // final mark, so neither hits
        send_packed(64'hFF00_FFFF_FFFF_FFFF, 8);     // full through the wildcard
        drain_block();

        // Signature 2 now takes a single 00 byte, and signature 1 the pair
        // FF FF: with both hit the lower index must be reported.
        write_reg(REG_LENGTHS, 64'h122);
        write_reg(REG_MASKS, 64'h01_BF_FF);
        end_writes();
        send_packed(64'hFFFF00, 3);
        drain_block();

        // Only two bytes are scanned, so the pair AB CD straddles the limit.
        // The writes to unused indexes carry all ones and must change nothing.
        write_reg(REG_SCAN_LIMIT, 64'h2);
        write_reg(REG_UNUSED_6, '1);
        write_reg(REG_UNUSED_7, '1);
        end_writes();
        send_packed(64'hCDAB11, 3);
        drain_block();

        // With a limit of zero no byte is scanned at all.
        write_reg(REG_SCAN_LIMIT, 64'h0);
        end_writes();
        send_packed(64'hCDAB00, 3);
        drain_block();

        // Random phases. Most images carry one or two planted signatures, some
        // carry a damaged copy, and the rest are plain noise.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_config();
            set_idling(idle_mode_e'(p % 4));
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                img_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                      : $urandom_range(1, 16);
                for (int i = 0; i < img_len; i++)
                    image_buf[i] = 8'($urandom_range(0, 255));
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    plant_signature($urandom_range(0, NUM_SIGNATURES - 1), img_len, 1'b0);
                    if (kind < 2)
                        plant_signature($urandom_range(0, NUM_SIGNATURES - 1), img_len, 1'b0);
                end
                else if (kind < 9)
                    plant_signature($urandom_range(0, NUM_SIGNATURES - 1), img_len, 1'b1);
                for (int i = 0; i < img_len; i++)
                    send_byte(image_buf[i], i == img_len - 1);
                sent += img_len;
            end
            drain_block();
        end

        sb.leftover_check();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Safety net: a run that hangs on a handshake ends here.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
